// ===== design/assert_macros.svh =====
// Shared assertion macros. Each expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pwq_pkg.sv =====
package pwq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_WOKEN     = 16;

   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int TASK_W   = 8;
   localparam int PRIO_W   = 8;
   localparam int TICK_W   = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_EXPIRE  = 2'd2,
      OP_REMOVE  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // Array move applied to every entry cell together.
   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_INSERT,
      STEP_POP,
      STEP_ROTATE
   } step_type;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] prio;
      logic [TICK_W-1:0] deadline;
   } entry_type;

   typedef struct packed {
      logic     capture;
      step_type step;
      logic     finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic out_free;
      logic pend_valid;
      logic head_hit;
      logic scan_done;
   } stat_type;

endpackage

// ===== design/pwq_req_if.sv =====
interface pwq_req_if;
   import pwq_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [TASK_W-1:0]   task_id;
   logic [PRIO_W-1:0]   priority_req;
   logic [TICK_W-1:0]   timeout;
   logic [TICK_W-1:0]   now_tick;

   modport source (output valid, opcode, task_id, priority_req, timeout, now_tick,
                   input ready);
   modport sink (input valid, opcode, task_id, priority_req, timeout, now_tick,
                 output ready);
endinterface

// ===== design/pwq_rsp_if.sv =====
interface pwq_rsp_if;
   import pwq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TASK_W-1:0]   out_task;
   logic                task_valid;
   logic                last;

   modport source (output valid, status, out_task, task_valid, last, input ready);
   modport sink (input valid, status, out_task, task_valid, last, output ready);
endinterface

// ===== design/pwq_datapath.sv =====
module pwq_datapath #(
   parameter int Depth = pwq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pwq_pkg::cmd_type              cmd,
   output pwq_pkg::stat_type             stat,
   input  logic [pwq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [pwq_pkg::TASK_W-1:0]    req_task_id,
   input  logic [pwq_pkg::PRIO_W-1:0]    req_priority,
   input  logic [pwq_pkg::TICK_W-1:0]    req_timeout,
   input  logic [pwq_pkg::TICK_W-1:0]    req_now_tick,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pwq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pwq_pkg::TASK_W-1:0]    rsp_out_task,
   output logic                          rsp_task_valid,
   output logic                          rsp_last
);
   import pwq_pkg::*;

   localparam int CntW   = $clog2(Depth + 1);
   localparam int WokenW = $clog2(MAX_WOKEN + 1);

   entry_type               entry_ff [Depth];
   entry_type               entry_in [Depth];
   logic [Depth-1:0]        ge;
   entry_type               head;

   logic [CntW-1:0]         count_ff, count_in;
   logic [CntW-1:0]         left_ff, left_in;
   logic [WokenW-1:0]       woken_ff, woken_in;

   opcode_type              op_ff;
   entry_type               new_ff;
   logic [TICK_W-1:0]       now_ff;
   logic                    full_ff;

   logic                    pend_valid_ff, pend_valid_in;
   logic [TASK_W-1:0]       pend_task_ff, pend_task_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [TASK_W-1:0]       rsp_task_ff, rsp_task_in;
   logic                    rsp_task_valid_ff, rsp_task_valid_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    hit_expire, hit_remove, head_hit;
   logic                    out_free, rotating, push_pend;

   assign head = entry_ff[0];

   assign hit_expire = (head.deadline != '0) && (head.deadline <= now_ff) &&
                       (woken_ff < WokenW'(MAX_WOKEN));
   assign hit_remove = !pend_valid_ff && (head.task_id == new_ff.task_id);

   always_comb begin
      case (op_ff)
         OP_EXPIRE: head_hit = hit_expire;
         OP_REMOVE: head_hit = hit_remove;
         default:   head_hit = 1'b0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rotating  = (cmd.step == STEP_ROTATE);
   // A second woken task pushes the held one out, not yet marked last.
   assign push_pend = rotating && head_hit && (op_ff == OP_EXPIRE) && pend_valid_ff;

   // Entry cells: each looks at itself and its two neighbors, plus the new entry and, at the tail, the head.
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      entry_type from_prev;
      entry_type from_next;
      logic      prev_ge;
      logic      is_tail;

      assign ge[i] = (CntW'(i) < count_ff) && (entry_ff[i].prio >= new_ff.prio);
      assign is_tail = (CntW'(i) == (count_ff - CntW'(1)));

      if (i == 0) begin : g_first
         assign prev_ge   = 1'b1;
         assign from_prev = new_ff;
      end else begin : g_rest
         assign prev_ge   = ge[i-1];
         assign from_prev = entry_ff[i-1];
      end

      if (i == Depth - 1) begin : g_last
         assign from_next = entry_ff[i];
      end else begin : g_inner
         assign from_next = entry_ff[i+1];
      end

      always_comb begin
         entry_in[i] = entry_ff[i];
         case (cmd.step)
            STEP_INSERT: begin
               if (!ge[i]) begin
                  entry_in[i] = prev_ge ? new_ff : from_prev;
               end
            end
            STEP_POP:    entry_in[i] = from_next;
            STEP_ROTATE: begin
               // Advance toward the head; a kept head goes back in at the tail.
               if (is_tail && !head_hit) begin
                  entry_in[i] = head;
               end else begin
                  entry_in[i] = from_next;
               end
            end
            default: ;
         endcase
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      left_in       = left_ff;
      woken_in      = woken_ff;
      pend_valid_in = pend_valid_ff;
      pend_task_in  = pend_task_ff;

      if (cmd.capture) begin
         left_in       = count_ff;
         woken_in      = '0;
         pend_valid_in = 1'b0;
      end

      case (cmd.step)
         STEP_INSERT: count_in = count_ff + CntW'(1);
         STEP_POP: begin
            count_in      = count_ff - CntW'(1);
            pend_valid_in = 1'b1;
            pend_task_in  = head.task_id;
         end
         STEP_ROTATE: begin
            left_in = left_ff - CntW'(1);
            if (head_hit) begin
               count_in      = count_ff - CntW'(1);
               pend_valid_in = 1'b1;
               pend_task_in  = head.task_id;
               if (op_ff == OP_EXPIRE) begin
                  woken_in = woken_ff + WokenW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_task_in       = rsp_task_ff;
      rsp_task_valid_in = rsp_task_valid_ff;
      rsp_last_in       = rsp_last_ff;

      if (push_pend) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = STAT_OK;
         rsp_task_in       = pend_task_ff;
         rsp_task_valid_in = 1'b1;
         rsp_last_in       = 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_in      = 1'b1;
         rsp_task_in       = pend_valid_ff ? pend_task_ff : '0;
         rsp_task_valid_in = pend_valid_ff;
         rsp_last_in       = 1'b1;
         unique case (op_ff)
            OP_ENQUEUE: rsp_status_in = full_ff ? STAT_FULL : STAT_OK;
            OP_DEQUEUE: rsp_status_in = pend_valid_ff ? STAT_OK : STAT_EMPTY;
            OP_EXPIRE:  rsp_status_in = pend_valid_ff ? STAT_OK : STAT_EMPTY;
            OP_REMOVE:  rsp_status_in = pend_valid_ff ? STAT_OK : STAT_NOT_FOUND;
            default:    rsp_status_in = STAT_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         left_ff       <= '0;
         woken_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         left_ff       <= left_in;
         woken_ff      <= woken_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff           <= opcode_type'(req_opcode);
         new_ff.task_id  <= req_task_id;
         new_ff.prio     <= req_priority;
         new_ff.deadline <= (req_timeout != '0) ? TICK_W'(req_now_tick + req_timeout) : '0;
         now_ff          <= req_now_tick;
         full_ff         <= (count_ff == CntW'(Depth));
      end
      pend_task_ff      <= pend_task_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_task_ff       <= rsp_task_in;
      rsp_task_valid_ff <= rsp_task_valid_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign stat.full       = (count_ff == CntW'(Depth));
   assign stat.empty      = (count_ff == '0);
   assign stat.out_free   = out_free;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.head_hit   = head_hit;
   assign stat.scan_done  = (left_ff == '0);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_task   = rsp_task_ff;
   assign rsp_task_valid = rsp_task_valid_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== design/pwq_ctrl.sv =====
module pwq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [pwq_pkg::OPCODE_W-1:0] req_opcode,
   output logic                         req_ready,
   output pwq_pkg::cmd_type             cmd,
   input  pwq_pkg::stat_type            stat
);
   import pwq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   opcode_type op_ff, op_in;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.step    = STEP_NONE;
      cmd.finish  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = opcode_type'(req_opcode);
               unique case (opcode_type'(req_opcode)) inside
                  OP_ENQUEUE, OP_DEQUEUE: state_in = S_EXEC;
                  OP_EXPIRE, OP_REMOVE:   state_in = S_SCAN;
               endcase
            end
         end
         S_EXEC: begin
            if (op_ff == OP_ENQUEUE) begin
               cmd.step = stat.full ? STEP_NONE : STEP_INSERT;
            end else begin
               cmd.step = stat.empty ? STEP_NONE : STEP_POP;
            end
            state_in = S_FINISH;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end else if (!(op_ff == OP_EXPIRE && stat.head_hit && stat.pend_valid &&
                           !stat.out_free)) begin
               cmd.step = STEP_ROTATE;
            end
            // otherwise hold until the result register frees up
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ENQUEUE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

// ===== design/priority_wait_queue_with_timeouts.sv =====
// Priority wait queue of up to Depth tasks, highest priority first and FIFO among
// equals, with optional deadlines. Enqueue and dequeue go through the execute and
// finish states to the result beat. Expire and remove make one pass that moves every
// queued entry once through the head of the entry array, dropping the tasks that
// leave and putting the rest back at the tail in order. Expire sends one beat per
// woken task (at most 16 per request; one beat without a task if none wakes) and
// stalls its pass while the result register is still held. A new request is taken
// only after the previous one has produced its last result beat.
`include "assert_macros.svh"

module priority_wait_queue_with_timeouts #(
   parameter int Depth = pwq_pkg::DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   pwq_req_if.sink   req_bus,
   pwq_rsp_if.source rsp_bus
);
   import pwq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic     insert_when_full;
   logic     finish_when_busy;
   logic     push_when_busy;
   logic     req_fire;

   pwq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   pwq_datapath #(
      .Depth (Depth)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_bus.opcode),
      .req_task_id    (req_bus.task_id),
      .req_priority   (req_bus.priority_req),
      .req_timeout    (req_bus.timeout),
      .req_now_tick   (req_bus.now_tick),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_status     (rsp_bus.status),
      .rsp_out_task   (rsp_bus.out_task),
      .rsp_task_valid (rsp_bus.task_valid),
      .rsp_last       (rsp_bus.last)
   );

   assign insert_when_full = (cmd.step == STEP_INSERT) && stat.full;
   assign finish_when_busy = cmd.finish && !stat.out_free;
   assign push_when_busy   = (cmd.step == STEP_ROTATE) && stat.head_hit && stat.pend_valid &&
                             !stat.out_free;
   assign req_fire         = req_bus.valid && req_bus.ready;

   `ASSERT_ALWAYS(a_no_insert_full, clock, reset, !insert_when_full, "insert into a full queue")
   `ASSERT_ALWAYS(a_finish_slot_free, clock, reset, !finish_when_busy, "final beat over held beat")
   `ASSERT_ALWAYS(a_push_slot_free, clock, reset, !push_when_busy, "woken task over held beat")
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_bus.ready, "second request taken")

endmodule
